// ===== rtl/frame_running_average_assert.svh =====
// assertion macros used by the frame running average controller
`ifndef FRAME_RUNNING_AVERAGE_ASSERT_SVH
`define FRAME_RUNNING_AVERAGE_ASSERT_SVH

// condition holds in the same cycle
`define FRA_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition holds in the next cycle
`define FRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/fra_pkg.sv =====
// shared constants and controller/datapath interface types for the running average
package fra_pkg;

	localparam int MAX_WINDOW_DEF = 16;
	localparam int MAX_ATOMS_DEF = 1024;
	localparam int COORD_BITS_DEF = 32;
	localparam int SUM_EXTRA = 4;
	localparam int LANES = 3;

	localparam int WIN_CFG_W = 5;
	localparam int ATOM_CFG_W = 11;
	localparam int CFG_DATA_W = 11;
	localparam int CFG_ADDR_W = 1;

	localparam int DEFAULT_WINDOW = 5;
	localparam int DEFAULT_ATOMS = 1;

	localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_ATOM_COUNT = 1'b1;

	typedef struct packed {
		logic load;
		logic upd;
		logic clr;
		logic div_step;
		logic out_load;
		logic subtract;
		logic last;
	} fra_cmd_t;

	typedef struct packed {
		logic out_busy;
	} fra_sts_t;

endpackage

// ===== rtl/fra_ctrl.sv =====
// controller: config registers, frame counters, sum clearing and item sequencing
`include "frame_running_average_assert.svh"

module fra_ctrl #(
	parameter int MAX_WINDOW = fra_pkg::MAX_WINDOW_DEF,
	parameter int MAX_ATOMS = fra_pkg::MAX_ATOMS_DEF,
	parameter int COORD_BITS = fra_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [fra_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [fra_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic s_tvalid,
	output logic s_tready,
	input  fra_pkg::fra_sts_t sts,
	output fra_pkg::fra_cmd_t cmd,
	output logic [((MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1)-1:0] sum_addr,
	output logic [((MAX_WINDOW * MAX_ATOMS > 1) ? $clog2(MAX_WINDOW * MAX_ATOMS) : 1)-1:0]
		hist_addr,
	output logic [(($clog2(MAX_WINDOW + 1) > fra_pkg::WIN_CFG_W) ?
		$clog2(MAX_WINDOW + 1) : fra_pkg::WIN_CFG_W) + 1 - 1:0] win
);

	localparam int IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
	localparam int HADDR_W = (MAX_WINDOW * MAX_ATOMS > 1) ? $clog2(MAX_WINDOW * MAX_ATOMS) : 1;
	localparam int WIN_W = $clog2(MAX_WINDOW + 1);
	localparam int WA_W = ((WIN_W > fra_pkg::WIN_CFG_W) ? WIN_W : fra_pkg::WIN_CFG_W) + 1;
	localparam int CNT_W = $clog2(MAX_ATOMS + 1);
	localparam int AT_W = ((CNT_W > fra_pkg::ATOM_CFG_W) ? CNT_W : fra_pkg::ATOM_CFG_W) + 1;
	localparam int SUM_W = COORD_BITS + fra_pkg::SUM_EXTRA;
	localparam int DC_W = $clog2(SUM_W);
	localparam logic [DC_W-1:0] DC_LAST = DC_W'(SUM_W - 1);
	localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(MAX_ATOMS - 1);

	localparam int ST_W = 3;
	localparam logic [ST_W-1:0] ST_CLEAR = 3'd0;
	localparam logic [ST_W-1:0] ST_IDLE = 3'd1;
	localparam logic [ST_W-1:0] ST_CALC = 3'd2;
	localparam logic [ST_W-1:0] ST_DIV = 3'd3;
	localparam logic [ST_W-1:0] ST_OUT = 3'd4;

	logic [ST_W-1:0] state_q;
	logic [fra_pkg::WIN_CFG_W-1:0] win_cfg_q;
	logic [fra_pkg::ATOM_CFG_W-1:0] atom_cfg_q;
	logic [IDX_W-1:0] atom_q;
	logic [SLOT_W-1:0] slot_q;
	logic [HADDR_W-1:0] base_q;
	logic [WIN_W-1:0] seen_q;
	logic [IDX_W-1:0] clr_q;
	logic [DC_W-1:0] divc_q;
	logic emit_q;

	logic [WA_W-1:0] w_eff;
	logic [AT_W-1:0] n_eff;
	logic [WA_W-1:0] seen_inc;
	logic [WA_W-1:0] slot_inc;
	logic subtract_c;
	logic emit_c;
	logic end_c;
	logic wrap_c;
	logic accept;

	always_comb begin
		if (win_cfg_q == '0) begin
			w_eff = WA_W'(1);
		end else if (WA_W'(win_cfg_q) > WA_W'(MAX_WINDOW)) begin
			w_eff = WA_W'(MAX_WINDOW);
		end else begin
			w_eff = WA_W'(win_cfg_q);
		end
		if (atom_cfg_q == '0) begin
			n_eff = AT_W'(1);
		end else if (AT_W'(atom_cfg_q) > AT_W'(MAX_ATOMS)) begin
			n_eff = AT_W'(MAX_ATOMS);
		end else begin
			n_eff = AT_W'(atom_cfg_q);
		end
	end

	assign seen_inc = WA_W'(seen_q) + WA_W'(1);
	assign slot_inc = WA_W'(slot_q) + WA_W'(1);
	assign subtract_c = WA_W'(seen_q) >= w_eff;
	assign emit_c = seen_inc >= w_eff;
	assign wrap_c = slot_inc >= w_eff;
	assign end_c = (AT_W'(atom_q) + AT_W'(1)) >= n_eff;

	assign s_tready = state_q == ST_IDLE;
	assign accept = s_tvalid && s_tready;
	assign win = w_eff;
	assign hist_addr = base_q + HADDR_W'(atom_q);
	assign sum_addr = (state_q == ST_CLEAR) ? clr_q : atom_q;

	always_comb begin
		cmd.load = accept;
		cmd.upd = state_q == ST_CALC;
		cmd.clr = state_q == ST_CLEAR;
		cmd.div_step = state_q == ST_DIV;
		cmd.out_load = (state_q == ST_OUT) && !sts.out_busy;
		cmd.subtract = subtract_c;
		cmd.last = end_c;
	end

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_cfg_q <= fra_pkg::WIN_CFG_W'(fra_pkg::DEFAULT_WINDOW);
			atom_cfg_q <= fra_pkg::ATOM_CFG_W'(fra_pkg::DEFAULT_ATOMS);
		end else if (cfg_we) begin
			unique case (cfg_addr)
				fra_pkg::REG_WINDOW_SIZE: win_cfg_q <= cfg_wdata[fra_pkg::WIN_CFG_W-1:0];
				fra_pkg::REG_ATOM_COUNT: atom_cfg_q <= cfg_wdata[fra_pkg::ATOM_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// frame position counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atom_q <= '0;
			slot_q <= '0;
			base_q <= '0;
			seen_q <= '0;
			emit_q <= 1'b0;
		end else if (accept) begin
			emit_q <= emit_c;
			if (end_c) begin
				atom_q <= '0;
				slot_q <= wrap_c ? '0 : slot_inc[SLOT_W-1:0];
				base_q <= wrap_c ? '0 : base_q + HADDR_W'(MAX_ATOMS);
				seen_q <= emit_c ? w_eff[WIN_W-1:0] : seen_inc[WIN_W-1:0];
			end else begin
				atom_q <= atom_q + IDX_W'(1);
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q <= '0;
			divc_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == CLR_LAST) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_CALC;
					end
				end
				ST_CALC: begin
					divc_q <= '0;
					state_q <= emit_q ? ST_DIV : ST_IDLE;
				end
				ST_DIV: begin
					divc_q <= divc_q + DC_W'(1);
					if (divc_q == DC_LAST) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (!sts.out_busy) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`FRA_ASSERT_NEXT(a_accept_calc, s_tvalid && s_tready, state_q == ST_CALC, "accepted word did not start update")
	`FRA_ASSERT_IMP(a_load_free, cmd.out_load, !sts.out_busy, "result loaded over pending word")
	`FRA_ASSERT_IMP(a_seen_max, state_q != ST_CLEAR, WA_W'(seen_q) <= WA_W'(MAX_WINDOW), "frame count past window limit")
	`FRA_ASSERT_NEXT(a_div_done, (state_q == ST_DIV) && (divc_q == DC_LAST), state_q == ST_OUT, "divide did not finish")

endmodule

// ===== rtl/fra_dp.sv =====
// datapath: history and sum memories, sum update, serial dividers and output register
module fra_dp #(
	parameter int MAX_WINDOW = fra_pkg::MAX_WINDOW_DEF,
	parameter int MAX_ATOMS = fra_pkg::MAX_ATOMS_DEF,
	parameter int COORD_BITS = fra_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  fra_pkg::fra_cmd_t cmd,
	output fra_pkg::fra_sts_t sts,
	input  logic [((MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1)-1:0] sum_addr,
	input  logic [((MAX_WINDOW * MAX_ATOMS > 1) ? $clog2(MAX_WINDOW * MAX_ATOMS) : 1)-1:0]
		hist_addr,
	input  logic [(($clog2(MAX_WINDOW + 1) > fra_pkg::WIN_CFG_W) ?
		$clog2(MAX_WINDOW + 1) : fra_pkg::WIN_CFG_W) + 1 - 1:0] win,
	input  logic [fra_pkg::LANES*COORD_BITS-1:0] coords,
	output logic out_valid,
	input  logic out_ready,
	output logic [fra_pkg::LANES*COORD_BITS-1:0] out_data,
	output logic out_last
);

	localparam int LANES = fra_pkg::LANES;
	localparam int IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int HDEPTH = MAX_WINDOW * MAX_ATOMS;
	localparam int HADDR_W = (HDEPTH > 1) ? $clog2(HDEPTH) : 1;
	localparam int WIN_W = $clog2(MAX_WINDOW + 1);
	localparam int WA_W = ((WIN_W > fra_pkg::WIN_CFG_W) ? WIN_W : fra_pkg::WIN_CFG_W) + 1;
	localparam int SUM_W = COORD_BITS + fra_pkg::SUM_EXTRA;
	localparam int HI_W = SUM_W - COORD_BITS + 1;

	typedef logic [LANES-1:0][COORD_BITS-1:0] coord_vec_t;
	typedef logic [LANES-1:0][SUM_W-1:0] sum_vec_t;

	coord_vec_t hist_mem [HDEPTH];
	sum_vec_t sum_mem [MAX_ATOMS];

	coord_vec_t coord_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [HADDR_W-1:0] haddr_s1;
	logic sub_s1;
	logic last_s1;
	coord_vec_t hist_rd_q;
	sum_vec_t sum_rd_q;

	sum_vec_t sum_new;
	sum_vec_t mag_q;
	logic [LANES-1:0][WA_W-1:0] rem_q;
	logic [LANES-1:0] neg_q;
	coord_vec_t avg_c;

	logic out_valid_q;
	coord_vec_t out_data_q;
	logic out_last_q;

	// item capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			coord_s1 <= coords;
			idx_s1 <= sum_addr;
			haddr_s1 <= hist_addr;
			sub_s1 <= cmd.subtract;
			last_s1 <= cmd.last;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.upd) begin
			hist_mem[haddr_s1] <= coord_s1;
		end
		if (cmd.load) begin
			hist_rd_q <= hist_mem[hist_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.clr) begin
			sum_mem[sum_addr] <= '0;
		end else if (cmd.upd) begin
			sum_mem[idx_s1] <= sum_new;
		end
		if (cmd.load) begin
			sum_rd_q <= sum_mem[sum_addr];
		end
	end

	// running sum update, wraps at the sum width
	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			sum_new[l] = sum_rd_q[l]
				- (sub_s1 ? SUM_W'(signed'(hist_rd_q[l])) : SUM_W'(0))
				+ SUM_W'(signed'(coord_s1[l]));
		end
	end

	// restoring divide of the magnitude, one quotient bit per step
	always_ff @(posedge clk) begin
		for (int l = 0; l < LANES; l++) begin
			if (cmd.upd) begin
				mag_q[l] <= sum_new[l][SUM_W-1] ? (SUM_W'(0) - sum_new[l]) : sum_new[l];
				neg_q[l] <= sum_new[l][SUM_W-1];
				rem_q[l] <= '0;
			end else if (cmd.div_step) begin
				if ({rem_q[l], mag_q[l][SUM_W-1]} >= {1'b0, win}) begin
					rem_q[l] <= WA_W'({rem_q[l], mag_q[l][SUM_W-1]} - {1'b0, win});
					mag_q[l] <= {mag_q[l][SUM_W-2:0], 1'b1};
				end else begin
					rem_q[l] <= {rem_q[l][WA_W-2:0], mag_q[l][SUM_W-1]};
					mag_q[l] <= {mag_q[l][SUM_W-2:0], 1'b0};
				end
			end
		end
	end

	// sign restore and saturation to the coordinate range
	always_comb begin
		logic [SUM_W-1:0] q;
		logic [HI_W-1:0] hi;
		for (int l = 0; l < LANES; l++) begin
			q = neg_q[l] ? (SUM_W'(0) - mag_q[l]) : mag_q[l];
			hi = q[SUM_W-1:COORD_BITS-1];
			if ((hi == '0) || (hi == '1)) begin
				avg_c[l] = q[COORD_BITS-1:0];
			end else if (q[SUM_W-1]) begin
				avg_c[l] = {1'b1, {(COORD_BITS-1){1'b0}}};
			end else begin
				avg_c[l] = {1'b0, {(COORD_BITS-1){1'b1}}};
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_data_q <= avg_c;
			out_last_q <= last_s1;
		end
	end

	assign sts.out_busy = out_valid_q && !out_ready;
	assign out_valid = out_valid_q;
	assign out_data = out_data_q;
	assign out_last = out_last_q;

endmodule

// ===== rtl/frame_running_average.sv =====
// top level of the frame running average block
// an accepted word passes the sum update, bit-serial divide and output load before
// m_axis_tvalid rises; s_axis_tready stays low until the result is loaded, and the load
// waits while m_axis_tvalid is high and m_axis_tready low; an item before the window
// fills gives no result and skips the divider; reset: window_size 5, atom_count 1,
// then all sums are cleared with s_axis_tready low; history memory is undefined until written
module frame_running_average #(
	parameter int MAX_WINDOW = fra_pkg::MAX_WINDOW_DEF,
	parameter int MAX_ATOMS = fra_pkg::MAX_ATOMS_DEF,
	parameter int COORD_BITS = fra_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [fra_pkg::CFG_ADDR_W-1:0] cfg_addr,
	input  logic [fra_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic s_axis_tvalid,
	output logic s_axis_tready,
	// coord_x, coord_y, coord_z
	input  logic [((fra_pkg::LANES * COORD_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
	output logic m_axis_tvalid,
	input  logic m_axis_tready,
	// avg_x, avg_y, avg_z
	output logic [((fra_pkg::LANES * COORD_BITS + 7) / 8) * 8-1:0] m_axis_tdata,
	output logic m_axis_tlast
);

	localparam int LANES = fra_pkg::LANES;
	localparam int DATA_W = ((LANES * COORD_BITS + 7) / 8) * 8;
	localparam int IDX_W = (MAX_ATOMS > 1) ? $clog2(MAX_ATOMS) : 1;
	localparam int HADDR_W = (MAX_WINDOW * MAX_ATOMS > 1) ? $clog2(MAX_WINDOW * MAX_ATOMS) : 1;
	localparam int WIN_W = $clog2(MAX_WINDOW + 1);
	localparam int WA_W = ((WIN_W > fra_pkg::WIN_CFG_W) ? WIN_W : fra_pkg::WIN_CFG_W) + 1;

	fra_pkg::fra_cmd_t cmd;
	fra_pkg::fra_sts_t sts;
	logic [IDX_W-1:0] sum_addr;
	logic [HADDR_W-1:0] hist_addr;
	logic [WA_W-1:0] win;
	logic [LANES*COORD_BITS-1:0] out_data;

	fra_ctrl #(
		.MAX_WINDOW(MAX_WINDOW),
		.MAX_ATOMS(MAX_ATOMS),
		.COORD_BITS(COORD_BITS)
	) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_addr(cfg_addr),
		.cfg_wdata(cfg_wdata),
		.s_tvalid(s_axis_tvalid),
		.s_tready(s_axis_tready),
		.sts(sts),
		.cmd(cmd),
		.sum_addr(sum_addr),
		.hist_addr(hist_addr),
		.win(win)
	);

	fra_dp #(
		.MAX_WINDOW(MAX_WINDOW),
		.MAX_ATOMS(MAX_ATOMS),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.sts(sts),
		.sum_addr(sum_addr),
		.hist_addr(hist_addr),
		.win(win),
		.coords(s_axis_tdata[LANES*COORD_BITS-1:0]),
		.out_valid(m_axis_tvalid),
		.out_ready(m_axis_tready),
		.out_data(out_data),
		.out_last(m_axis_tlast)
	);

	assign m_axis_tdata = DATA_W'(out_data);

endmodule
